### hdl/b2r_pkg.sv
package b2r_pkg;

    localparam int unsigned HEADER_BYTES = 54;
    localparam int unsigned HDR_IDX_W    = 6;

    typedef logic [HDR_IDX_W-1:0] t_hdr_idx;

    localparam t_hdr_idx HDR_LAST    = t_hdr_idx'(HEADER_BYTES - 1);
    localparam t_hdr_idx IDX_TYPE_LO = 6'd0;
    localparam t_hdr_idx IDX_TYPE_HI = 6'd1;
    localparam t_hdr_idx IDX_W_LO    = 6'd18;
    localparam t_hdr_idx IDX_W_HI_F  = 6'd19;
    localparam t_hdr_idx IDX_W_HI_L  = 6'd21;
    localparam t_hdr_idx IDX_H_LO    = 6'd22;
    localparam t_hdr_idx IDX_H_HI_F  = 6'd23;
    localparam t_hdr_idx IDX_H_HI_L  = 6'd25;
    localparam t_hdr_idx IDX_COMP_F  = 6'd30;
    localparam t_hdr_idx IDX_COMP_L  = 6'd33;

    localparam logic [15:0] BM_MAGIC = 16'h4D42;

    localparam logic [7:0] RST_DISP_W = 8'd128;
    localparam logic [7:0] RST_DISP_H = 8'd160;
    localparam logic [7:0] RST_MAX_W  = 8'd128;
    localparam logic [7:0] RST_MAX_H  = 8'd160;

    localparam int unsigned CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISP_W = 4'd0,
        CFG_DISP_H = 4'd1,
        CFG_MAX_W  = 4'd2,
        CFG_MAX_H  = 4'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXEL  = 2'd1,
        PH_ERROR  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_WINDOW = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_TYPE       = 2'd0,
        ERR_WIDE       = 2'd1,
        ERR_TALL       = 2'd2,
        ERR_COMPRESSED = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        TRI_BLUE  = 2'd0,
        TRI_GREEN = 2'd1,
        TRI_RED   = 2'd2,
        TRI_IDLE  = 2'd3
    } t_triple;

endpackage

### hdl/b2r_byte_if.sv
interface b2r_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       file_start;

    modport source (output valid, output file_byte, output file_start, input ready);
    modport sink   (input valid, input file_byte, input file_start, output ready);
endinterface

### hdl/b2r_res_if.sv
interface b2r_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] color;
    logic [7:0]  win_x0;
    logic [7:0]  win_y0;
    logic [7:0]  win_x1;
    logic [7:0]  win_y1;
    logic [1:0]  error_code;

    modport source (
        output valid, output kind, output color, output win_x0, output win_y0,
        output win_x1, output win_y1, output error_code, input ready
    );
    modport sink (
        input valid, input kind, input color, input win_x0, input win_y0,
        input win_x1, input win_y1, input error_code, output ready
    );
endinterface

### hdl/bmp24_to_rgb565_streamer.sv
// Latency: a result is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the only register between the sides is the result
// register, and a new byte is taken whenever that register is empty or being drained.
// Reset (synchronous, active low) returns the parser to header byte 0 with all
// header fields cleared and loads the panel and limit registers with 128 and 160.
module bmp24_to_rgb565_streamer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [b2r_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_wdata,
    b2r_byte_if.sink                            i_byte,
    b2r_res_if.source                           o_res
);
    import b2r_pkg::*;

    // Configuration registers.
    logic [7:0] r_disp_w, r_disp_h, r_max_w, r_max_h;

    // Parser state. Upper bytes of the 32-bit header words only matter as "nonzero".
    t_phase     r_phase,    n_phase;
    t_hdr_idx   r_hdr_idx,  n_hdr_idx;
    logic [15:0] r_type,    n_type;
    logic [7:0] r_w_lo,     n_w_lo;
    logic       r_w_hi,     n_w_hi;
    logic [7:0] r_h_lo,     n_h_lo;
    logic       r_h_hi,     n_h_hi;
    logic       r_comp,     n_comp;
    logic [1:0] r_pad_len,  n_pad_len;
    logic [1:0] r_pad_cnt,  n_pad_cnt;
    logic [7:0] r_pix_cnt,  n_pix_cnt;
    t_triple    r_triple,   n_triple;
    logic [7:0] r_blue,     n_blue;
    logic [7:0] r_green,    n_green;

    // Result register.
    logic        r_valid;
    t_kind       r_kind,    n_kind;
    logic [15:0] r_color,   n_color;
    logic [7:0]  r_x0, r_y0, r_x1, r_y1;
    logic [7:0]  n_x0, n_y0, n_x1, n_y1;
    t_err        r_err,     n_err;
    logic        n_has_res;

    logic       in_ready;
    logic       accept;
    logic [7:0] b;
    t_phase     cur_phase;
    t_hdr_idx   cur_idx;
    logic       b_nz;
    logic [8:0] dx, dy, sx, sy;

    assign in_ready     = !r_valid || o_res.ready;
    assign i_byte.ready = in_ready;
    assign accept       = i_byte.valid && in_ready;
    assign b            = i_byte.file_byte;
    assign b_nz         = (b != 8'd0);

    // Window corners: halves of 9-bit differences and sums. The width and height
    // bytes are already stored by the time the last header byte arrives.
    assign dx = {1'b0, r_disp_w} - {1'b0, r_w_lo};
    assign dy = {1'b0, r_disp_h} - {1'b0, r_h_lo};
    assign sx = {1'b0, r_disp_w} + {1'b0, r_w_lo};
    assign sy = {1'b0, r_disp_h} + {1'b0, r_h_lo};

    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_type    = r_type;
        n_w_lo    = r_w_lo;
        n_w_hi    = r_w_hi;
        n_h_lo    = r_h_lo;
        n_h_hi    = r_h_hi;
        n_comp    = r_comp;
        n_pad_len = r_pad_len;
        n_pad_cnt = r_pad_cnt;
        n_pix_cnt = r_pix_cnt;
        n_triple  = r_triple;
        n_blue    = r_blue;
        n_green   = r_green;
        n_has_res = 1'b0;
        n_kind    = KIND_PIXEL;
        n_color   = 16'd0;
        n_x0      = 8'd0;
        n_y0      = 8'd0;
        n_x1      = 8'd0;
        n_y1      = 8'd0;
        n_err     = ERR_TYPE;
        cur_phase = r_phase;
        cur_idx   = r_hdr_idx;

        // A file start clears everything and the byte becomes header byte 0.
        if (i_byte.file_start) begin
            cur_phase = PH_HEADER;
            cur_idx   = '0;
            n_type    = '0;
            n_w_lo    = '0;
            n_w_hi    = 1'b0;
            n_h_lo    = '0;
            n_h_hi    = 1'b0;
            n_comp    = 1'b0;
            n_pad_len = '0;
            n_pad_cnt = '0;
            n_pix_cnt = '0;
            n_triple  = TRI_BLUE;
            n_blue    = '0;
            n_green   = '0;
        end
        n_phase   = cur_phase;
        n_hdr_idx = cur_idx;

        if (accept) begin
            unique case (cur_phase)
                PH_HEADER: begin
                    case (cur_idx) inside
                        IDX_TYPE_LO:               n_type[7:0]  = b;
                        IDX_TYPE_HI:               n_type[15:8] = b;
                        IDX_W_LO:                  n_w_lo       = b;
                        [IDX_W_HI_F:IDX_W_HI_L]:   n_w_hi       = n_w_hi | b_nz;
                        IDX_H_LO:                  n_h_lo       = b;
                        [IDX_H_HI_F:IDX_H_HI_L]:   n_h_hi       = n_h_hi | b_nz;
                        [IDX_COMP_F:IDX_COMP_L]:   n_comp       = n_comp | b_nz;
                        default: ;
                    endcase
                    n_hdr_idx = cur_idx + t_hdr_idx'(1);
                    if (cur_idx == HDR_LAST) begin
                        n_has_res = 1'b1;
                        if (n_type != BM_MAGIC) begin
                            n_err = ERR_TYPE;
                        end else if (n_w_hi || (n_w_lo > r_max_w)) begin
                            n_err = ERR_WIDE;
                        end else if (n_h_hi || (n_h_lo > r_max_h)) begin
                            n_err = ERR_TALL;
                        end else begin
                            n_err = ERR_COMPRESSED;
                        end
                        if ((n_type != BM_MAGIC) || n_w_hi || (n_w_lo > r_max_w) ||
                            n_h_hi || (n_h_lo > r_max_h) || n_comp) begin
                            n_phase = PH_ERROR;
                            n_kind  = KIND_REJECT;
                        end else begin
                            n_phase   = PH_PIXEL;
                            n_kind    = KIND_WINDOW;
                            n_err     = ERR_TYPE;
                            // Row padding to a multiple of four bytes equals width mod 4.
                            n_pad_len = n_w_lo[1:0];
                            n_pad_cnt = '0;
                            n_pix_cnt = '0;
                            n_triple  = TRI_BLUE;
                            n_x0      = dx[8:1];
                            n_y0      = dy[8:1];
                            n_x1      = sx[8:1] - 8'd1;
                            n_y1      = sy[8:1] - 8'd1;
                        end
                    end
                end
                PH_PIXEL: begin
                    if (r_pad_cnt != 2'd0) begin
                        if (r_pad_cnt >= r_pad_len) begin
                            n_pad_cnt = '0;
                        end else begin
                            n_pad_cnt = r_pad_cnt + 2'd1;
                        end
                    end else begin
                        case (r_triple) inside
                            TRI_BLUE, TRI_IDLE: begin
                                n_blue   = b;
                                n_triple = TRI_GREEN;
                            end
                            TRI_GREEN: begin
                                n_green  = b;
                                n_triple = TRI_RED;
                            end
                            default: begin
                                n_triple  = TRI_BLUE;
                                n_has_res = 1'b1;
                                n_kind    = KIND_PIXEL;
                                n_color   = {b[7:3], r_green[7:2], r_blue[7:3]};
                                // Rows are tracked only when they carry padding.
                                if (r_pad_len != 2'd0) begin
                                    if ((r_pix_cnt + 8'd1) >= r_w_lo) begin
                                        n_pad_cnt = 2'd1;
                                        n_pix_cnt = '0;
                                    end else begin
                                        n_pix_cnt = r_pix_cnt + 8'd1;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= RST_DISP_W;
            r_disp_h <= RST_DISP_H;
            r_max_w  <= RST_MAX_W;
            r_max_h  <= RST_MAX_H;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DISP_W: r_disp_w <= i_cfg_wdata;
                CFG_DISP_H: r_disp_h <= i_cfg_wdata;
                CFG_MAX_W:  r_max_w  <= i_cfg_wdata;
                CFG_MAX_H:  r_max_h  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_idx <= '0;
            r_type    <= '0;
            r_w_lo    <= '0;
            r_w_hi    <= 1'b0;
            r_h_lo    <= '0;
            r_h_hi    <= 1'b0;
            r_comp    <= 1'b0;
            r_pad_len <= '0;
            r_pad_cnt <= '0;
            r_pix_cnt <= '0;
            r_triple  <= TRI_BLUE;
            r_blue    <= '0;
            r_green   <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_type    <= n_type;
            r_w_lo    <= n_w_lo;
            r_w_hi    <= n_w_hi;
            r_h_lo    <= n_h_lo;
            r_h_hi    <= n_h_hi;
            r_comp    <= n_comp;
            r_pad_len <= n_pad_len;
            r_pad_cnt <= n_pad_cnt;
            r_pix_cnt <= n_pix_cnt;
            r_triple  <= n_triple;
            r_blue    <= n_blue;
            r_green   <= n_green;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ready) begin
            r_valid <= accept && n_has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_has_res) begin
            r_kind  <= n_kind;
            r_color <= n_color;
            r_x0    <= n_x0;
            r_y0    <= n_y0;
            r_x1    <= n_x1;
            r_y1    <= n_y1;
            r_err   <= n_err;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.kind       = r_kind;
    assign o_res.color      = r_color;
    assign o_res.win_x0     = r_x0;
    assign o_res.win_y0     = r_y0;
    assign o_res.win_x1     = r_x1;
    assign o_res.win_y1     = r_y1;
    assign o_res.error_code = r_err;

    // The pad counter never runs past the row's pad length.
    a_pad_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXEL) |-> (r_pad_cnt <= r_pad_len))
        else $error("pad counter beyond pad length");

    // The last header byte always produces a window or a reject result.
    a_hdr_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_byte.file_start && (r_phase == PH_HEADER) && (r_hdr_idx == HDR_LAST))
        |=> (r_valid && (r_kind != KIND_PIXEL)))
        else $error("header end without a result");

    // While parsing the header the index stays inside the header.
    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_hdr_idx <= HDR_LAST))
        else $error("header index out of range");

    // Pixel words only come out of the pixel phase.
    a_pixel_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_has_res && (n_kind == KIND_PIXEL)) |-> (r_phase == PH_PIXEL))
        else $error("pixel word outside pixel phase");

endmodule

### tb/sv/bmp24_to_rgb565_tb_check.sv
module bmp24_to_rgb565_tb_check import b2r_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    b2r_byte_if                  byte_ch,
    b2r_res_if                   res_ch,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] color;
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic [7:0]  x1;
        logic [7:0]  y1;
        t_err        err;
    } t_bmp_out;

    // Panel and limit registers as the block should hold them.
    logic [7:0] disp_w, disp_h, max_w, max_h;

    // Parser state.
    t_hdr_idx    hdr_pos;
    t_phase      ph;
    logic [15:0] bmp_type;
    logic [31:0] bmp_w, bmp_h, bmp_comp;
    logic [1:0]  pad_len, pad_left;
    logic [7:0]  px_in_row;
    t_triple     tri_slot;
    logic [7:0]  blue, green;

    t_bmp_out awaited_out[$];
    t_bmp_out want;
    int       fails = 0;
    int       backlog = 0;

    assign o_fail_count = fails;
    assign o_pending    = backlog;

    function automatic void clear_parse();
        hdr_pos   = '0;
        ph        = PH_HEADER;
        bmp_type  = '0;
        bmp_w     = '0;
        bmp_h     = '0;
        bmp_comp  = '0;
        pad_len   = '0;
        pad_left  = '0;
        px_in_row = '0;
        tri_slot  = TRI_BLUE;
        blue      = '0;
        green     = '0;
    endfunction

    // Works out what one accepted byte does to the parser and queues the result it causes.
    function automatic void absorb_byte(input logic [7:0] b, input logic s);
        t_bmp_out   o;
        int         pos;
        logic [7:0] w8, h8;
        logic [9:0] dx, dy;
        logic [8:0] sx, sy;
        logic [1:0] tail;
        o = '0;
        if (s) clear_parse();
        pos = int'(hdr_pos);
        case (ph)
            PH_HEADER: begin
                if (pos < 2) bmp_type[pos*8 +: 8] = b;
                else if (pos >= 18 && pos < 22) bmp_w[(pos-18)*8 +: 8] = b;
                else if (pos >= 22 && pos < 26) bmp_h[(pos-22)*8 +: 8] = b;
                else if (pos >= 30 && pos < 34) bmp_comp[(pos-30)*8 +: 8] = b;
                hdr_pos = hdr_pos + 1'b1;
                if (t_hdr_idx'(pos) == HDR_LAST) begin
                    o.kind = KIND_REJECT;
                    if (bmp_type != BM_MAGIC) o.err = ERR_TYPE;
                    else if (bmp_w > 32'(max_w)) o.err = ERR_WIDE;
                    else if (bmp_h > 32'(max_h)) o.err = ERR_TALL;
                    else if (bmp_comp != 0) o.err = ERR_COMPRESSED;
                    else o.kind = KIND_WINDOW;
                    if (o.kind == KIND_REJECT) begin
                        ph = PH_ERROR;
                    end else begin
                        w8 = bmp_w[7:0];
                        h8 = bmp_h[7:0];
                        // The left and top corners are half of a 10-bit signed difference.
                        dx = {2'b00, disp_w} - {2'b00, w8};
                        dy = {2'b00, disp_h} - {2'b00, h8};
                        sx = {1'b0, disp_w} + {1'b0, w8};
                        sy = {1'b0, disp_h} + {1'b0, h8};
                        o.x0 = dx[8:1];
                        o.y0 = dy[8:1];
                        o.x1 = sx[8:1] - 8'd1;
                        o.y1 = sy[8:1] - 8'd1;
                        tail = 2'(w8[1:0] * 2'd3);
                        pad_len   = 2'd0 - tail;
                        pad_left  = '0;
                        px_in_row = '0;
                        tri_slot  = TRI_BLUE;
                        ph        = PH_PIXEL;
                    end
                    awaited_out.push_back(o);
                end
            end
            PH_PIXEL: begin
                if (pad_left != 0) begin
                    if (pad_left >= pad_len) pad_left = '0;
                    else pad_left = pad_left + 1'b1;
                end else begin
                    case (tri_slot)
                        TRI_GREEN: begin
                            green    = b;
                            tri_slot = TRI_RED;
                        end
                        TRI_RED: begin
                            tri_slot = TRI_BLUE;
                            o.kind   = KIND_PIXEL;
                            o.color  = {b[7:3], green[7:2], blue[7:3]};
                            // Rows are only tracked when there is padding to skip.
                            if (pad_len != 0) begin
                                px_in_row = px_in_row + 1'b1;
                                if (32'(px_in_row) >= bmp_w) begin
                                    pad_left  = 2'd1;
                                    px_in_row = '0;
                                end
                            end
                            awaited_out.push_back(o);
                        end
                        default: begin
                            blue     = b;
                            tri_slot = TRI_GREEN;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            fails++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            disp_w = RST_DISP_W;
            disp_h = RST_DISP_H;
            max_w  = RST_MAX_W;
            max_h  = RST_MAX_H;
            awaited_out.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (awaited_out.size() == 0) begin
                    fails++;
                    $display("%0t: expected no item, got kind %0d color 0x%h error %0d",
                             $time, res_ch.kind, res_ch.color, res_ch.error_code);
                end else begin
                    want = awaited_out.pop_front();
                    check_field("kind", 16'(want.kind), 16'(res_ch.kind));
                    check_field("color", want.color, res_ch.color);
                    check_field("win_x0", 16'(want.x0), 16'(res_ch.win_x0));
                    check_field("win_y0", 16'(want.y0), 16'(res_ch.win_y0));
                    check_field("win_x1", 16'(want.x1), 16'(res_ch.win_x1));
                    check_field("win_y1", 16'(want.y1), 16'(res_ch.win_y1));
                    check_field("error_code", 16'(want.err), 16'(res_ch.error_code));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DISP_W: disp_w = i_cfg_wdata;
                    CFG_DISP_H: disp_h = i_cfg_wdata;
                    CFG_MAX_W:  max_w  = i_cfg_wdata;
                    CFG_MAX_H:  max_h  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready) begin
                absorb_byte(byte_ch.file_byte, byte_ch.file_start);
            end
        end
        backlog = awaited_out.size();
    end

endmodule

### tb/sv/bmp24_to_rgb565_streamer_tb.sv
module bmp24_to_rgb565_streamer_tb import b2r_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int PHASE_BYTES  = 180;
    localparam int SPARE_IDX_LO = int'(CFG_MAX_H) + 1;
    localparam int SPARE_IDX_HI = (1 << CFG_IDX_W) - 1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_wdata;

    int         idle_pct = 0;
    int         stall_pct = 0;
    int         useful_bytes = 0;
    int         cycles = 0;
    int         fail_total;
    int         outstanding;
    logic [7:0] lim_w = RST_MAX_W;
    logic [7:0] lim_h = RST_MAX_H;

    b2r_byte_if byte_ch ();
    b2r_res_if  res_ch ();

    bmp24_to_rgb565_streamer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (byte_ch),
        .o_res       (res_ch)
    );

    bmp24_to_rgb565_tb_check u_tb_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .byte_ch      (byte_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_total),
        .o_pending    (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b, input logic s, input logic counted);
        while ($urandom_range(99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.file_byte  <= b;
        byte_ch.file_start <= s;
        do @(posedge i_clk); while (!byte_ch.ready);
        if (counted) useful_bytes++;
        @(negedge i_clk);
    endtask

    // Waits until every queued result has drained and the block has gone quiet.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_MAX_W: lim_w = val;
            CFG_MAX_H: lim_h = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic program_panel(input logic [7:0] dw, input logic [7:0] dh,
                                 input logic [7:0] mw, input logic [7:0] mh);
        write_reg(CFG_DISP_W, dw);
        write_reg(CFG_DISP_H, dh);
        write_reg(CFG_MAX_W, mw);
        write_reg(CFG_MAX_H, mh);
        // A write to an unused index must not disturb any register.
        write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)), 8'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Sends the first cut header bytes, then pixel bytes if the header is complete.
    task automatic send_file(input logic [15:0] ftype, input logic [31:0] fw,
                             input logic [31:0] fh, input logic [31:0] fcomp,
                             input logic start, input int cut, input int npix);
        logic [7:0] b;
        logic       fits;
        fits = ftype == BM_MAGIC && fw <= 32'(lim_w) && fh <= 32'(lim_h) && fcomp == 0;
        for (int i = 0; i < cut; i++) begin
            if (i < 2) b = ftype[i*8 +: 8];
            else if (i >= 18 && i < 22) b = fw[(i-18)*8 +: 8];
            else if (i >= 22 && i < 26) b = fh[(i-22)*8 +: 8];
            else if (i >= 30 && i < 34) b = fcomp[(i-30)*8 +: 8];
            else b = 8'($urandom);
            send_byte(b, start && i == 0, 1'b1);
        end
        if (cut < int'(HEADER_BYTES)) return;
        // After a rejected header the block only ignores bytes, so send just a few.
        if (!fits && npix > 4) npix = 4;
        for (int i = 0; i < npix; i++) begin
            case ($urandom_range(6))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_byte(b, 1'b0, fits);
        end
    endtask

    task automatic rand_file();
        logic [15:0] ftype;
        logic [31:0] fw, fh, fcomp;
        int          r, cut, row_bytes, rows;
        r = $urandom_range(99);
        if (r < 4) ftype = 16'($urandom);
        else if (r < 7) ftype = BM_MAGIC ^ (16'd1 << $urandom_range(15));
        else ftype = BM_MAGIC;
        r = $urandom_range(99);
        if (r < 5) fw = 32'(lim_w) + 32'($urandom_range(1, 300));
        else if (r < 8) fw = $urandom;
        else if (r < 11) fw = 32'(lim_w);
        else fw = $urandom_range(0, (lim_w < 10) ? lim_w : 10);
        r = $urandom_range(99);
        if (r < 4) fh = {1'b1, 31'($urandom)};
        else if (r < 8) fh = 32'(lim_h) + 32'($urandom_range(1, 300));
        else if (r < 11) fh = 32'(lim_h);
        else fh = $urandom_range(0, (lim_h < 6) ? lim_h : 6);
        fcomp = ($urandom_range(99) < 5) ? ($urandom | (32'd1 << $urandom_range(31))) : '0;
        cut = ($urandom_range(99) < 6) ? $urandom_range(1, HEADER_BYTES - 1) : HEADER_BYTES;
        row_bytes = (fw <= 255) ? 3 * int'(fw) + int'(fw[1:0]) : 0;
        rows = (fw > 10) ? $urandom_range(1) : $urandom_range(3);
        send_file(ftype, fw, fh, fcomp, 1'b1, cut,
                  rows * row_bytes + $urandom_range(0, 5));
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_DISP_W;
        i_cfg_wdata        = '0;
        byte_ch.valid      = 1'b0;
        byte_ch.file_byte  = '0;
        byte_ch.file_start = 1'b0;
        res_ch.ready       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed files on the reset panel; the first one comes without a file start.
        send_file(BM_MAGIC, 32'd2, 32'd2, '0, 1'b0, HEADER_BYTES, 16);
        send_file(BM_MAGIC, 32'd3, 32'd1, '0, 1'b1, HEADER_BYTES, 30);
        send_file(BM_MAGIC ^ 16'h0100, 32'd1, 32'd1, '0, 1'b1, HEADER_BYTES, 3);
        send_file(BM_MAGIC, 32'd129, 32'd1, '0, 1'b1, HEADER_BYTES, 3);
        send_file(BM_MAGIC, 32'd1, 32'd161, '0, 1'b1, HEADER_BYTES, 3);
        send_file(BM_MAGIC, 32'd4, 32'hFFFF_FFF0, '0, 1'b1, HEADER_BYTES, 3);
        send_file(BM_MAGIC, 32'd1, 32'd1, 32'd1, 1'b1, HEADER_BYTES, 5);
        send_file(16'h0000, 32'hFFFF_FFFF, 32'd500, 32'hFFFF_FFFF, 1'b1, HEADER_BYTES, 2);
        send_file(BM_MAGIC, 32'd200, 32'd200, 32'd1, 1'b1, HEADER_BYTES, 2);
        send_file(BM_MAGIC, 32'd0, 32'd0, '0, 1'b1, HEADER_BYTES, 9);
        send_file(BM_MAGIC, 32'd2, 32'd2, '0, 1'b1, 20, 0);
        send_file(BM_MAGIC, 32'd1, 32'd1, '0, 1'b1, HEADER_BYTES, 4);
        send_file(BM_MAGIC, 32'd128, 32'd160, '0, 1'b1, HEADER_BYTES, 7);
        settle();

        // Panel smaller than the bitmap, so the corners wrap.
        program_panel(8'd1, 8'd1, 8'd255, 8'd255);
        send_file(BM_MAGIC, 32'd255, 32'd255, '0, 1'b1, HEADER_BYTES, 12);
        send_file(BM_MAGIC, 32'd0, 32'd0, '0, 1'b1, HEADER_BYTES, 3);
        send_file(BM_MAGIC, 32'd1, 32'd1, '0, 1'b1, HEADER_BYTES, 6);
        settle();
        program_panel(8'd255, 8'd255, 8'd1, 8'd1);
        send_file(BM_MAGIC, 32'd1, 32'd1, '0, 1'b1, HEADER_BYTES, 8);
        send_file(BM_MAGIC, 32'd2, 32'd1, '0, 1'b1, HEADER_BYTES, 3);
        send_file(BM_MAGIC, 32'd1, 32'd2, '0, 1'b1, HEADER_BYTES, 3);

        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    program_panel(8'd255, 8'd255, 8'd255, 8'd255);
                end
                1: begin
                    idle_pct  = 48;
                    stall_pct = 0;
                    program_panel(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                  8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 48;
                    program_panel(8'd1, 8'd1, 8'($urandom_range(1, 12)),
                                  8'($urandom_range(1, 12)));
                end
                default: begin
                    idle_pct  = 11;
                    stall_pct = 11;
                    program_panel(RST_DISP_W, RST_DISP_H, RST_MAX_W, RST_MAX_H);
                end
            endcase
            useful_bytes = 0;
            while (useful_bytes < PHASE_BYTES) begin
                if ($urandom_range(99) < 12) begin
                    // Noise: random bytes with the odd stray file start.
                    repeat ($urandom_range(1, 24)) begin
                        send_byte(8'($urandom), $urandom_range(99) < 8, 1'b1);
                    end
                end else begin
                    rand_file();
                end
            end
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (fail_total == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
